### src/lbs_pkg.sv
// Shared types, codes and widths for the bounded LIFO stack.
package lbs_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int CAP_W  = 7;
	localparam int ADDR_W = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
	localparam logic [OP_W-1:0] OP_DISPLAY = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// register file
	localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;
	localparam logic             REG_CAPACITY = 1'b0;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic shift_dn;
		logic shift_up;
		logic wrap;
	} cell_cmd_t;

endpackage

### src/lbs_cell.sv
// One stack cell: holds one word and trades it with its neighbors.
module lbs_cell (
	input  logic                       clk,
	input  lbs_pkg::cell_cmd_t         cmd,
	input  logic                       is_bottom,
	input  logic [lbs_pkg::DATA_W-1:0] up_data,
	input  logic [lbs_pkg::DATA_W-1:0] down_data,
	input  logic [lbs_pkg::DATA_W-1:0] top_data,
	output logic [lbs_pkg::DATA_W-1:0] data_q
);
	import lbs_pkg::*;

	// push takes from above; pop and rotate take from below, bottom wraps to top
	always_ff @(posedge clk) begin
		if (cmd.shift_dn) begin
			data_q <= up_data;
		end else if (cmd.shift_up) begin
			data_q <= (cmd.wrap && is_bottom) ? top_data : down_data;
		end
	end

endmodule

### src/bounded_lifo_stack_core.sv
// Top level of the bounded LIFO stack: control, config register and cell chain.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | in_valid / in_stall    | operation, push_value
//  out     | output    | out_valid / out_stall  | status, result_value, last
//  apb     | input     | psel/penable/pready    | capacity at byte address 0
//
// Push, pop and peek give one result each; a new word is accepted every cycle
// unless out stalls or a display runs. Display of N entries gives N results by
// rotating the occupied cells past cell 0, and holds off input until the last
// result is loaded. A result register sits on the output; a stall on out holds
// it and stalls in. Reset clears the entry count, the display sequencer and the
// output valid; capacity resets to 64. Cell contents have no reset.
module bounded_lifo_stack_core #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [lbs_pkg::OP_W-1:0]    operation,
	input  logic signed [lbs_pkg::DATA_W-1:0] push_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lbs_pkg::ST_W-1:0]    status,
	output logic signed [lbs_pkg::DATA_W-1:0] result_value,
	output logic                        last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lbs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import lbs_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CAP_W-1:0]  capacity_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rem_q;
	logic              disp_q;
	logic              out_valid_q;
	logic [ST_W-1:0]   status_q;
	logic [DATA_W-1:0] value_q;
	logic              last_q;

	logic [DATA_W-1:0] data_w [DEPTH];
	cell_cmd_t         cmd;
	logic              in_acc;
	logic              ld;
	logic              full;
	logic [CAP_W-1:0]  lim;
	logic              cfg_wr;
	logic              reg_hit;

	// configuration port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1] == REG_CAPACITY);
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? {{(32-CAP_W){1'b0}}, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// handshake: output register frees when empty or taken
	assign ld       = !out_valid_q || !out_stall;
	assign in_stall = disp_q || !ld;
	assign in_acc   = in_valid && !in_stall;

	// effective limit saturates at DEPTH
	assign lim  = (capacity_q > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity_q;
	assign full = (CAP_W'(count_q) >= lim);

	// cell commands
	always_comb begin
		cmd = '0;
		if (in_acc) begin
			case (operation)
				OP_PUSH: begin
					cmd.shift_dn = !full;
				end
				OP_POP: begin
					cmd.shift_up = (count_q != '0);
				end
				OP_DISPLAY: begin
					cmd.shift_up = (count_q != '0);
					cmd.wrap     = 1'b1;
				end
				default: begin
					cmd = '0;
				end
			endcase
		end else if (disp_q && ld) begin
			cmd.shift_up = 1'b1;
			cmd.wrap     = 1'b1;
		end
	end

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rem_q       <= '0;
			disp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
			if (operation == OP_PUSH && !full) begin
				count_q <= count_q + CW'(1);
			end else if (operation == OP_POP && count_q != '0) begin
				count_q <= count_q - CW'(1);
			end else if (operation == OP_DISPLAY && count_q > CW'(1)) begin
				disp_q <= 1'b1;
				rem_q  <= count_q - CW'(1);
			end
		end else if (disp_q && ld) begin
			out_valid_q <= 1'b1;
			rem_q       <= rem_q - CW'(1);
			if (rem_q == CW'(1)) begin
				disp_q <= 1'b0;
			end
		end else if (ld) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q <= 1'b1;
			if (operation == OP_PUSH) begin
				status_q <= full ? ST_FULL : ST_OK;
				value_q  <= '0;
			end else if (count_q == '0) begin
				status_q <= ST_EMPTY;
				value_q  <= '0;
			end else begin
				status_q <= ST_OK;
				value_q  <= data_w[0];
				if (operation == OP_DISPLAY) begin
					last_q <= (count_q == CW'(1));
				end
			end
		end else if (disp_q && ld) begin
			status_q <= ST_OK;
			value_q  <= data_w[0];
			last_q   <= (rem_q == CW'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = value_q;
	assign last         = last_q;

	// cell chain, cell 0 is the top of stack
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] up_w;
		logic [DATA_W-1:0] down_w;

		if (i == 0) begin : g_top
			assign up_w = push_value;
		end else begin : g_mid
			assign up_w = data_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign down_w = data_w[i];
		end else begin : g_link
			assign down_w = data_w[i+1];
		end

		lbs_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.is_bottom (count_q == CW'(i + 1)),
			.up_data   (up_w),
			.down_data (down_w),
			.top_data  (data_w[0]),
			.data_q    (data_w[i])
		);
	end

	// checks
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && operation == OP_PUSH && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not advance entry count");

	a_disp_pending: assert property (@(posedge clk) disable iff (!arst_n)
		disp_q |-> out_valid_q)
		else $error("display running without a pending result");

	a_disp_rem: assert property (@(posedge clk) disable iff (!arst_n)
		disp_q |-> (rem_q != '0) && (rem_q < count_q))
		else $error("display remainder out of range");

	a_disp_count: assert property (@(posedge clk) disable iff (!arst_n)
		disp_q |=> count_q == $past(count_q))
		else $error("entry count changed during display");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(value_q) && $stable(last_q))
		else $error("stalled result changed");

endmodule

### tb/bounded_lifo_stack_core_tb.sv
// Testbench for the bounded LIFO stack core: directed, backpressure and random traffic.
module bounded_lifo_stack_core_tb;
	import lbs_pkg::*;

	localparam int STACK_DEPTH   = 64;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 1000;
	localparam int MAX_REPORTS   = 10;
	localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * REG_CAPACITY);

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} reply_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] push_value;
	logic                     out_valid;
	logic                     out_stall;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] result_value;
	logic                     last;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;

	// shadow of the stack contents, depth and capacity register
	logic signed [DATA_W-1:0] stack_shadow [STACK_DEPTH];
	int unsigned              entry_total = 0;
	logic [CAP_W-1:0]         cap_shadow  = CAP_RESET;
	reply_t                   pending_replies [$];

	int mismatch_cnt = 0;
	int hold_len     = 0;
	bit idle_enable  = 1'b1;

	bounded_lifo_stack_core #(
		.DEPTH(STACK_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.result_value(result_value),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void log_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t mismatch: %s", $realtime, msg);
	endfunction

	function automatic void add_reply(input logic [ST_W-1:0] st,
		input logic signed [DATA_W-1:0] val, input logic fin);
		reply_t r;
		r.status = st;
		r.value  = val;
		r.last   = fin;
		pending_replies.push_back(r);
	endfunction

	// advance the shadow stack by one accepted word and queue its replies
	function automatic void predict_stack_op(input logic [OP_W-1:0] op,
		input logic signed [DATA_W-1:0] val);
		int unsigned lim;
		lim = (cap_shadow > STACK_DEPTH) ? STACK_DEPTH : cap_shadow;
		if (op == OP_PUSH) begin
			if (entry_total >= lim) begin
				add_reply(ST_FULL, '0, 1'b1);
			end else begin
				stack_shadow[entry_total] = val;
				entry_total++;
				add_reply(ST_OK, '0, 1'b1);
			end
		end else if (entry_total == 0) begin
			add_reply(ST_EMPTY, '0, 1'b1);
		end else if (op == OP_POP) begin
			entry_total--;
			add_reply(ST_OK, stack_shadow[entry_total], 1'b1);
		end else if (op == OP_PEEK) begin
			add_reply(ST_OK, stack_shadow[entry_total - 1], 1'b1);
		end else begin
			for (int i = entry_total; i > 0; i--)
				add_reply(ST_OK, stack_shadow[i - 1], i == 1);
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return OP_PUSH;
		if (r < push_pct + 8)
			return OP_DISPLAY;
		if (r < push_pct + 20)
			return OP_PEEK;
		return OP_POP;
	endfunction

	// offer one word after a random gap, hold it until accepted
	task automatic send_word(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
		int gap;
		gap = idle_enable ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation  = op;
		push_value = val;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_stack_op(op, val);
	endtask

	// drop valid and wait until every queued reply has come back
	task automatic settle_stack();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_capacity();
		logic [31:0] got;
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = CAPACITY_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (got[CAP_W-1:0] !== cap_shadow)
			log_mismatch($sformatf("capacity read expected %0d, got %0d",
				cap_shadow, got[CAP_W-1:0]));
	endtask

	// write the capacity register, then read it back
	task automatic set_capacity(input logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = CAPACITY_ADDR;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		cap_shadow = data[CAP_W-1:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		read_capacity();
	endtask

	task automatic test_empty_stack();
		read_capacity();
		send_word(OP_POP, rand_word());
		send_word(OP_PEEK, rand_word());
		send_word(OP_DISPLAY, rand_word());
	endtask

	task automatic test_push_extremes();
		send_word(OP_PUSH, 32'h8000_0000);
		send_word(OP_PUSH, 32'h7FFF_FFFF);
		send_word(OP_PUSH, 32'h0000_0000);
		send_word(OP_PUSH, 32'hFFFF_FFFF);
		send_word(OP_PEEK, rand_word());
		send_word(OP_DISPLAY, rand_word());
		send_word(OP_POP, rand_word());
	endtask

	task automatic test_capacity_edges();
		// lower capacity below the three stored entries
		settle_stack();
		set_capacity(32'd2);
		send_word(OP_PUSH, 32'h1234_5678);
		send_word(OP_POP, rand_word());
		send_word(OP_PUSH, 32'h1234_5678);
		send_word(OP_DISPLAY, rand_word());
		send_word(OP_POP, rand_word());
		send_word(OP_POP, rand_word());
		send_word(OP_POP, rand_word());
		// zero capacity on an empty stack
		settle_stack();
		set_capacity(32'd0);
		send_word(OP_PUSH, rand_word());
		send_word(OP_PEEK, rand_word());
		// single-entry stack
		settle_stack();
		set_capacity(32'd1);
		send_word(OP_PUSH, rand_word());
		send_word(OP_PUSH, rand_word());
		send_word(OP_PEEK, rand_word());
		send_word(OP_POP, rand_word());
	endtask

	task automatic test_backpressure_fill();
		settle_stack();
		// low bits all ones: capacity above depth saturates
		set_capacity(32'hFFFF_FFFF);
		hold_len = 150;
		repeat (STACK_DEPTH + 2) send_word(OP_PUSH, rand_word());
		send_word(OP_DISPLAY, rand_word());
		repeat (10) send_word(OP_POP, rand_word());
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] cap;
		for (int phase = 0; phase < 6; phase++) begin
			settle_stack();
			idle_enable = (phase % 3) != 2;
			case (phase % 3)
				0: cap = $urandom_range(1, 8);
				1: cap = $urandom_range(9, 127);
				default: cap = $urandom_range(0, 64);
			endcase
			set_capacity({(phase % 2) ? 25'($urandom()) : 25'd0, cap});
			for (int n = 0; n < 20; n++) begin
				// pause the sender mid-phase until the stack has drained its replies
				if (phase == 3 && n == 12)
					settle_stack();
				send_word(pick_op((phase % 2) ? 35 : 65), rand_word());
			end
		end
		idle_enable = 1'b1;
	endtask

	// drive reset and run the tests in turn
	initial begin : stimulus
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = OP_PUSH;
		push_value = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_stack();
		test_push_extremes();
		test_capacity_edges();
		test_backpressure_fill();
		test_random_traffic();
		settle_stack();

		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// stall the output for a random count per word, plus any requested hold
	initial begin : reply_drain
		int wait_n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			wait_n = idle_enable ? $urandom_range(0, 3) : 0;
			wait_n += hold_len;
			hold_len = 0;
			if (wait_n > 0) begin
				out_stall = 1'b1;
				repeat (wait_n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// compare each accepted reply with the oldest queued one
	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				log_mismatch($sformatf("unexpected word status=%0d value=%0d last=%0b",
					status, result_value, last));
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status || result_value !== want.value
					|| last !== want.last)
					log_mismatch($sformatf(
						"expected status=%0d value=%0d last=%0b, got %0d %0d %0b",
						want.status, want.value, want.last,
						status, result_value, last));
			end
		end
	end

	// end the run when no word moves on any port for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable && pready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule
